// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, codes, item layouts and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int MAX_COLS_DEF = 80;
  localparam int MAX_ROWS_DEF = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CW_W   = 8;
  localparam int RH_W   = 6;
  localparam int PROD_W = CW_W + RH_W;
  localparam int OFF_W  = 11;
  localparam int CELL_W = 16;
  localparam int BYTE_W = 8;
  localparam int MOD_W  = 8;
  localparam int MOD_CNT_W = $clog2(MOD_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd2;

  localparam logic [BYTE_W-1:0] RESET_COLOR   = 8'h07;
  localparam logic [COL_W-1:0]  RESET_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]  RESET_ROWS    = 5'd25;

  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] INIT_CELL  = {RESET_COLOR, BLANK_CHAR};

  localparam logic [BYTE_W-1:0] CHAR_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd128;

  typedef enum logic [1:0] {
    FUNC_PUT,
    FUNC_GOTO,
    FUNC_CLEAR,
    FUNC_READ
  } func_t;

  typedef struct packed {
    logic [BYTE_W-1:0] row;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] char_code;
    func_t             func;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [OFF_W-1:0]  cursor_offset;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_item_t;

  localparam int IN_ITEM_W   = $bits(in_item_t);
  localparam int IN_DATA_W   = ((IN_ITEM_W + 7) / 8) * 8;
  localparam int OUT_ITEM_W  = $bits(out_item_t);
  localparam int OUT_DATA_W  = ((OUT_ITEM_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_CHAR,
    WR_BS,
    WR_BLANK
  } wr_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_CR,
    CUR_LF,
    CUR_ADV,
    CUR_BS,
    CUR_GOTO_COL,
    CUR_GOTO_ROW,
    CUR_HOME
  } cur_op_t;

  typedef struct packed {
    logic    latch;
    wr_op_t  wr;
    cur_op_t cur;
    logic    scan_clr;
    logic    scan_inc;
    logic    rd_copy;
    logic    mul_inrow;
    logic    mod_load;
    logic    mod_row;
    logic    mod_step;
    logic    cell_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] char_code;
    logic              last_col;
    logic              last_row;
    logic              in_range;
    logic              mod_last;
    logic              scan_copy;
    logic              scan_last_area;
    logic              scan_last_init;
    logic              out_free;
  } status_t;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the clearing pass, operation dispatch, remainder steps, scroll
// and clear sweeps, cell reads and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD_COL,
    ST_COL_WB,
    ST_MOD_ROW,
    ST_ROW_WB,
    ST_COPY,
    ST_BLANK,
    ST_READ,
    ST_READ_DATA,
    ST_FINISH,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   printable;

  assign printable = (status.char_code >= PRINT_LO) && (status.char_code < PRINT_HI);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.wr       = WR_INIT;
        cmd.scan_inc = 1'b1;
        if (status.scan_last_init) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.func)
          FUNC_PUT: begin
            state_next = ST_FINISH;
            if (status.char_code == CHAR_CR) begin
              cmd.cur = CUR_CR;
            end else if (status.char_code == CHAR_LF) begin
              cmd.cur = CUR_LF;
              if (status.last_row) begin
                cmd.scan_clr = 1'b1;
                state_next   = ST_COPY;
              end
            end else if (status.char_code == CHAR_BS) begin
              cmd.wr  = WR_BS;
              cmd.cur = CUR_BS;
            end else if (printable) begin
              cmd.wr  = WR_CHAR;
              cmd.cur = CUR_ADV;
              if (status.last_col && status.last_row) begin
                cmd.scan_clr = 1'b1;
                state_next   = ST_COPY;
              end
            end
          end
          FUNC_GOTO: begin
            cmd.mod_load = 1'b1;
            state_next   = ST_MOD_COL;
          end
          FUNC_CLEAR: begin
            cmd.scan_clr = 1'b1;
            cmd.cur      = CUR_HOME;
            state_next   = ST_BLANK;
          end
          FUNC_READ: begin
            if (status.in_range) begin
              cmd.mul_inrow = 1'b1;
              state_next    = ST_READ;
            end else begin
              state_next = ST_FINISH;
            end
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_MOD_COL: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = ST_COL_WB;
        end
      end
      ST_COL_WB: begin
        cmd.cur      = CUR_GOTO_COL;
        cmd.mod_load = 1'b1;
        cmd.mod_row  = 1'b1;
        state_next   = ST_MOD_ROW;
      end
      ST_MOD_ROW: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = ST_ROW_WB;
        end
      end
      ST_ROW_WB: begin
        cmd.cur    = CUR_GOTO_ROW;
        state_next = ST_FINISH;
      end
      ST_COPY: begin
        if (status.scan_copy) begin
          cmd.rd_copy  = 1'b1;
          cmd.scan_inc = 1'b1;
        end else begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.wr       = WR_BLANK;
        cmd.scan_inc = 1'b1;
        if (status.scan_last_area) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        cmd.cell_load = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == ST_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !s_tready)
    else $error("item port open during clearing pass");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !status.out_free) |=> (state == ST_RESULT))
    else $error("result dropped while output register busy");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready == (state == ST_IDLE))
    else $error("item port open outside the idle state");
`endif

endmodule

// ===== rtl/core/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// Text console writer datapath
// Configuration registers, cursor, screen store, address arithmetic, the
// bit-serial remainder unit and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_dp #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tcw_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  tcw_pkg::cmd_t                      cmd,
  output tcw_pkg::status_t                   status
);
  import tcw_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCAN_W = $clog2(DEPTH + 1);

  function automatic logic [CW_W-1:0] eff_cols(input logic [COL_W-1:0] v);
    logic [CW_W-1:0] ext;
    ext = {1'b0, v};
    if (v == '0) begin
      return CW_W'(1);
    end else if (ext > CW_W'(MAX_COLS)) begin
      return CW_W'(MAX_COLS);
    end
    return ext;
  endfunction

  function automatic logic [RH_W-1:0] eff_rows(input logic [ROW_W-1:0] v);
    logic [RH_W-1:0] ext;
    ext = {1'b0, v};
    if (v == '0) begin
      return RH_W'(1);
    end else if (ext > RH_W'(MAX_ROWS)) begin
      return RH_W'(MAX_ROWS);
    end
    return ext;
  endfunction

  logic [BYTE_W-1:0]    text_color;
  logic [COL_W-1:0]     columns;
  logic [ROW_W-1:0]     rows;
  logic [CW_W-1:0]      eff_w;
  logic [RH_W-1:0]      eff_h;
  logic [CW_W-1:0]      w_m1;
  logic [RH_W-1:0]      h_m1;
  logic [CW_W-1:0]      new_w;
  logic [RH_W-1:0]      new_h;

  logic [COL_W-1:0]     cur_col;
  logic [ROW_W-1:0]     cur_row;
  logic [COL_W-1:0]     cur_col_next;
  logic [ROW_W-1:0]     cur_row_next;
  logic                 last_col;
  logic                 last_row;

  in_item_t             item;
  logic [ROW_W-1:0]     mul_row;
  logic [PROD_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_b;
  logic [PROD_W-1:0]    area_b;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    area;
  logic [PROD_W-1:0]    t_cur;
  logic [PROD_W-1:0]    t_bs;
  logic [PROD_W-1:0]    t_read;
  logic [PROD_W-1:0]    t_copy;
  logic [PROD_W-1:0]    scan_ext;

  logic [SCAN_W-1:0]    scan;
  logic                 copy_pend;
  logic [ADDR_W-1:0]    copy_waddr;

  logic [CELL_W-1:0]    mem [DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    waddr;
  logic [CELL_W-1:0]    wdata;
  logic [ADDR_W-1:0]    raddr;
  logic [CELL_W-1:0]    rdata;
  logic [CELL_W-1:0]    blank;
  logic [CELL_W-1:0]    cell_val;

  logic [MOD_W-1:0]     mod_rem;
  logic [MOD_W-1:0]     mod_dvd;
  logic [MOD_W-1:0]     mod_div;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [MOD_W:0]       mod_trial;

  out_item_t            out_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
      columns    <= RESET_COLUMNS;
      rows       <= RESET_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR: text_color <= cfg_data;
        REG_COLUMNS:    columns    <= cfg_data[COL_W-1:0];
        REG_ROWS:       rows       <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w    = eff_cols(columns);
    eff_h    = eff_rows(rows);
    w_m1     = eff_w - CW_W'(1);
    h_m1     = eff_h - RH_W'(1);
    new_w    = eff_cols(cfg_data[COL_W-1:0]);
    new_h    = eff_rows(cfg_data[ROW_W-1:0]);
    last_col = ({1'b0, cur_col} == w_m1);
    last_row = ({1'b0, cur_row} == h_m1);
  end

  // Cursor update.
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    case (cmd.cur)
      CUR_CR: begin
        cur_col_next = '0;
      end
      CUR_LF: begin
        cur_col_next = '0;
        if (!last_row) begin
          cur_row_next = cur_row + ROW_W'(1);
        end
      end
      CUR_ADV: begin
        if (last_col) begin
          cur_col_next = '0;
          if (!last_row) begin
            cur_row_next = cur_row + ROW_W'(1);
          end
        end else begin
          cur_col_next = cur_col + COL_W'(1);
        end
      end
      CUR_BS: begin
        if (cur_col != '0) begin
          cur_col_next = cur_col - COL_W'(1);
        end else if (cur_row != '0) begin
          cur_row_next = cur_row - ROW_W'(1);
          cur_col_next = w_m1[COL_W-1:0];
        end
      end
      CUR_GOTO_COL: cur_col_next = mod_rem[COL_W-1:0];
      CUR_GOTO_ROW: cur_row_next = mod_rem[ROW_W-1:0];
      CUR_HOME: begin
        cur_col_next = '0;
        cur_row_next = '0;
      end
      default: ;
    endcase
    if (cfg_we && cfg_index == REG_COLUMNS && {1'b0, cur_col} >= new_w) begin
      cur_col_next = COL_W'(new_w - CW_W'(1));
    end
    if (cfg_we && cfg_index == REG_ROWS && {1'b0, cur_row} >= new_h) begin
      cur_row_next = ROW_W'(new_h - RH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
    end
  end

  // Row stride products, each registered.
  always_comb begin
    mul_row  = cmd.mul_inrow ? item.row[ROW_W-1:0] : cur_row;
    mul_a    = PROD_W'(mul_row);
    mul_b    = PROD_W'(eff_w);
    area_b   = PROD_W'(eff_h);
    t_cur    = prod + PROD_W'(cur_col);
    t_bs     = t_cur - PROD_W'(t_cur != '0);
    t_read   = prod + PROD_W'(item.col);
    scan_ext = PROD_W'(scan);
    t_copy   = scan_ext + mul_b;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    area <= mul_b * area_b;
  end

  // Sweep pointer for the clearing pass, scroll and clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan      <= '0;
      copy_pend <= 1'b0;
    end else begin
      copy_pend <= cmd.rd_copy;
      if (cmd.scan_clr) begin
        scan <= '0;
      end else if (cmd.scan_inc) begin
        scan <= scan + SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr <= scan[ADDR_W-1:0];
  end

  // Screen store write and read selection.
  always_comb begin
    blank  = {text_color, BLANK_CHAR};
    mem_we = 1'b0;
    waddr  = scan[ADDR_W-1:0];
    wdata  = blank;
    if (copy_pend) begin
      mem_we = 1'b1;
      waddr  = copy_waddr;
      wdata  = rdata;
    end else begin
      case (cmd.wr)
        WR_INIT: begin
          mem_we = 1'b1;
          wdata  = INIT_CELL;
        end
        WR_CHAR: begin
          mem_we = 1'b1;
          waddr  = t_cur[ADDR_W-1:0];
          wdata  = {text_color, item.char_code};
        end
        WR_BS: begin
          mem_we = 1'b1;
          waddr  = t_bs[ADDR_W-1:0];
        end
        WR_BLANK: begin
          mem_we = 1'b1;
        end
        default: ;
      endcase
    end
    raddr = cmd.rd_copy ? t_copy[ADDR_W-1:0] : t_read[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cell_val <= '0;
    end else if (cmd.cell_load) begin
      cell_val <= rdata;
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  assign mod_trial = {mod_rem, mod_dvd[MOD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (cmd.mod_load) begin
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + MOD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      mod_rem <= '0;
      mod_dvd <= cmd.mod_row ? item.row : item.col;
      mod_div <= cmd.mod_row ? MOD_W'(eff_h) : MOD_W'(eff_w);
    end else if (cmd.mod_step) begin
      mod_dvd <= {mod_dvd[MOD_W-2:0], 1'b0};
      if (mod_trial >= {1'b0, mod_div}) begin
        mod_rem <= MOD_W'(mod_trial - {1'b0, mod_div});
      end else begin
        mod_rem <= mod_trial[MOD_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.cursor_col    <= cur_col;
      out_item.cursor_row    <= cur_row;
      out_item.cursor_offset <= t_cur[OFF_W-1:0];
      out_item.cell_data     <= cell_val;
    end
  end

  assign m_tdata = OUT_DATA_W'(out_item);

  always_comb begin
    status                = '0;
    status.func           = item.func;
    status.char_code      = item.char_code;
    status.last_col       = last_col;
    status.last_row       = last_row;
    status.in_range       = (item.col < eff_w) && (item.row < BYTE_W'(eff_h));
    status.mod_last       = (mod_cnt == MOD_CNT_W'(MOD_W - 1));
    status.scan_copy      = scan_ext < (area - mul_b);
    status.scan_last_area = scan_ext == (area - PROD_W'(1));
    status.scan_last_init = scan == SCAN_W'(DEPTH - 1);
    status.out_free       = !m_tvalid || m_tready;
  end

`ifndef SYNTHESIS
  a_cursor_in_area: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < eff_w) && ({1'b0, cur_row} < eff_h))
    else $error("cursor outside the active area");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    copy_pend |-> (cmd.wr == WR_NONE))
    else $error("store write port claimed twice");

  a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_step |=> (mod_rem < mod_div))
    else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Clear and scroll sweep one store cell per sweep cycle. One item is in
// work at a time; the next is accepted once its result enters the output
// register. Reset is synchronous; a clearing pass blanks the store before
// the first item.
// ----------------------------------------------------------------------------
// Text console writer
// Character cell screen store with cursor: put character, goto, clear and
// cell read, with one result item per input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // func, char_code, col, row
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // cursor_col, cursor_row, cursor_offset, cell_data
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== dv/text_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put character, goto, clear and cell read items through the stream
// ports. A built-in model of the screen store and cursor predicts every result.
// A directed table runs first. Random traffic follows under several screen
// sizes and colors, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int SCREEN_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    func_t             f;
    logic [BYTE_W-1:0] ch;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] r;
    logic              known;
    out_item_t         res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic                  hold_req = 1'b0;
  logic                  hold_done = 1'b0;
  int unsigned           rx_hold_left = 0;
  int unsigned           rx_cyc = 0;
  int unsigned           rx_mode = 0;
  int unsigned           idle_cycles = 0;

  logic [CELL_W-1:0]     screen_mem [0:SCREEN_CELLS-1];
  int unsigned           cur_c;
  int unsigned           cur_r;
  logic [BYTE_W-1:0]     color_reg;
  logic [COL_W-1:0]      col_reg;
  logic [ROW_W-1:0]      row_reg;

  out_item_t             result_q [$];
  out_item_t             seen;
  out_item_t             want;
  dir_row_t              dir_tab [$];
  int unsigned           burst_left = 0;
  int unsigned           err_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           results_seen = 0;
  int unsigned           sweep_count = 0;
  int unsigned           size_settings = 1;

  text_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned width_in_use();
    if (col_reg == 0) return 1;
    if (col_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return col_reg;
  endfunction

  function automatic int unsigned height_in_use();
    if (row_reg == 0) return 1;
    if (row_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return row_reg;
  endfunction

  function automatic void console_reset();
    color_reg = RESET_COLOR;
    col_reg   = RESET_COLUMNS;
    row_reg   = RESET_ROWS;
    cur_c     = 0;
    cur_r     = 0;
    for (int i = 0; i < SCREEN_CELLS; i++) screen_mem[i] = INIT_CELL;
  endfunction

  function automatic void clamp_cursor();
    if (cur_c >= width_in_use()) cur_c = width_in_use() - 1;
    if (cur_r >= height_in_use()) cur_r = height_in_use() - 1;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_TEXT_COLOR: color_reg = v;
      REG_COLUMNS: begin
        col_reg = v[COL_W-1:0];
        clamp_cursor();
      end
      REG_ROWS: begin
        row_reg = v[ROW_W-1:0];
        clamp_cursor();
      end
      default: ;
    endcase
  endfunction

  function automatic void scroll_screen();
    int unsigned w;
    int unsigned h;
    int unsigned t;
    w = width_in_use();
    h = height_in_use();
    for (t = 0; t < w * (h - 1); t++) screen_mem[t] = screen_mem[t + w];
    for (; t < w * h; t++) screen_mem[t] = {color_reg, BLANK_CHAR};
    sweep_count++;
  endfunction

  function automatic out_item_t console_step(in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned t;
    out_item_t   res;
    w   = width_in_use();
    h   = height_in_use();
    res = '0;
    case (it.func)
      FUNC_PUT: begin
        if (it.char_code == CHAR_CR) begin
          cur_c = 0;
        end else if (it.char_code == CHAR_LF) begin
          cur_c = 0;
          cur_r++;
        end else if (it.char_code == CHAR_BS) begin
          t = cur_r * w + cur_c;
          if (t > 0) t--;
          cur_c = t % w;
          cur_r = t / w;
          screen_mem[t] = {color_reg, BLANK_CHAR};
        end else if (it.char_code >= PRINT_LO && it.char_code < PRINT_HI) begin
          screen_mem[cur_r * w + cur_c] = {color_reg, it.char_code};
          cur_c++;
          if (cur_c >= w) begin
            cur_c = 0;
            cur_r++;
          end
        end
        if (cur_r >= h) begin
          scroll_screen();
          cur_r = h - 1;
        end
      end
      FUNC_GOTO: begin
        cur_c = it.col % w;
        cur_r = it.row % h;
      end
      FUNC_CLEAR: begin
        for (t = 0; t < w * h; t++) screen_mem[t] = {color_reg, BLANK_CHAR};
        cur_c = 0;
        cur_r = 0;
        sweep_count++;
      end
      default: begin
        if (it.col < w && it.row < h) res.cell_data = screen_mem[it.row * w + it.col];
      end
    endcase
    res.cursor_col    = COL_W'(cur_c);
    res.cursor_row    = ROW_W'(cur_r);
    res.cursor_offset = OFF_W'(cur_r * w + cur_c);
    return res;
  endfunction

  function automatic dir_row_t op_row(func_t f, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] c,
                                      logic [BYTE_W-1:0] r, bit known, int unsigned ecol,
                                      int unsigned erow, int unsigned eoff, int unsigned edata);
    dir_row_t d;
    d.f                 = f;
    d.ch                = ch;
    d.c                 = c;
    d.r                 = r;
    d.known             = known;
    d.res.cursor_col    = COL_W'(ecol);
    d.res.cursor_row    = ROW_W'(erow);
    d.res.cursor_offset = OFF_W'(eoff);
    d.res.cell_data     = CELL_W'(edata);
    return d;
  endfunction

  // Mostly printable text with line control, so the cursor wraps and the
  // screen scrolls; the rest is moves, reads, clears and ignored bytes.
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned sel;
    it  = in_item_t'(IN_ITEM_W'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      it.func      = FUNC_PUT;
      it.char_code = 8'($urandom_range(32, 127));
    end else if (sel < 60) begin
      it.func = FUNC_PUT;
      case ($urandom_range(0, 2))
        0:       it.char_code = CHAR_CR;
        1:       it.char_code = CHAR_LF;
        default: it.char_code = CHAR_BS;
      endcase
    end else if (sel < 65) begin
      it.func      = FUNC_PUT;
      it.char_code = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(128, 255))
                                                  : 8'($urandom_range(0, 31));
    end else if (sel < 75) begin
      it.func = FUNC_GOTO;
    end else if (sel < 92) begin
      it.func = FUNC_READ;
      it.col  = 8'($urandom_range(0, width_in_use() - 1));
      it.row  = 8'($urandom_range(0, height_in_use() - 1));
    end else if (sel < 97) begin
      it.func = FUNC_READ;
    end else begin
      it.func = FUNC_CLEAR;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_v);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp_v);
    err_count++;
  endtask

  task automatic send_item(input in_item_t it, input bit known, input out_item_t known_res);
    int unsigned gap;
    out_item_t   pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata  <= IN_DATA_W'(it);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = console_step(it);
    result_q.push_back(known ? known_res : pred);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] color_v,
                            input logic [CFG_DATA_W-1:0] cols_v,
                            input logic [CFG_DATA_W-1:0] rows_v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEXT_COLOR;
    cfg_data  <= color_v;
    @(posedge clk);
    apply_config(REG_TEXT_COLOR, color_v);
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols_v;
    @(posedge clk);
    apply_config(REG_COLUMNS, cols_v);
    cfg_index <= REG_ROWS;
    cfg_data  <= rows_v;
    @(posedge clk);
    apply_config(REG_ROWS, rows_v);
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] color_v,
                           input logic [CFG_DATA_W-1:0] cols_v,
                           input logic [CFG_DATA_W-1:0] rows_v,
                           input int unsigned n, input bit long_hold);
    set_config(color_v, cols_v, rows_v);
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 3) hold_req <= 1'b1;
      send_item(rand_item(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        m_tready     <= 1'b0;
      end else if (hold_req && !hold_done) begin
        rx_hold_left <= 400;
        hold_done    <= 1'b1;
        m_tready     <= 1'b0;
      end else begin
        if (rx_cyc[6:0] == 7'd0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = out_item_t'(m_tdata[OUT_ITEM_W-1:0]);
      results_seen++;
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing pending, offset", seen.cursor_offset, 0);
      end else begin
        want = result_q.pop_front();
        if (seen.cursor_col != want.cursor_col)
          report_mismatch("cursor_col", seen.cursor_col, want.cursor_col);
        if (seen.cursor_row != want.cursor_row)
          report_mismatch("cursor_row", seen.cursor_row, want.cursor_row);
        if (seen.cursor_offset != want.cursor_offset)
          report_mismatch("cursor_offset", seen.cursor_offset, want.cursor_offset);
        if (seen.cell_data != want.cell_data)
          report_mismatch("cell_data", seen.cell_data, want.cell_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    console_reset();
    dir_tab = '{
      op_row(FUNC_READ,  8'h00,   8'd0,   8'd0,   1, 0,  0,  0,    16'h0720),
      op_row(FUNC_READ,  8'h00,   8'd79,  8'd24,  1, 0,  0,  0,    16'h0720),
      op_row(FUNC_READ,  8'h00,   8'd80,  8'd0,   1, 0,  0,  0,    0),
      op_row(FUNC_READ,  8'hFF,   8'd255, 8'd255, 1, 0,  0,  0,    0),
      op_row(FUNC_PUT,   8'h41,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_READ,  8'h00,   8'd0,   8'd0,   1, 1,  0,  1,    16'h0741),
      op_row(FUNC_PUT,   CHAR_BS, 8'd0,   8'd0,   1, 0,  0,  0,    0),
      op_row(FUNC_PUT,   CHAR_BS, 8'd0,   8'd0,   1, 0,  0,  0,    0),
      op_row(FUNC_PUT,   8'h7F,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_PUT,   8'h80,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_PUT,   8'hFF,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_PUT,   8'h00,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_PUT,   8'h1F,   8'd0,   8'd0,   1, 1,  0,  1,    0),
      op_row(FUNC_PUT,   8'h20,   8'd0,   8'd0,   1, 2,  0,  2,    0),
      op_row(FUNC_PUT,   CHAR_CR, 8'd0,   8'd0,   1, 0,  0,  0,    0),
      op_row(FUNC_PUT,   CHAR_LF, 8'd0,   8'd0,   1, 0,  1,  80,   0),
      op_row(FUNC_GOTO,  8'h00,   8'd255, 8'd255, 1, 15, 5,  415,  0),
      op_row(FUNC_GOTO,  8'h00,   8'd79,  8'd24,  1, 79, 24, 1999, 0),
      op_row(FUNC_PUT,   8'h7A,   8'd0,   8'd0,   1, 0,  24, 1920, 0),
      op_row(FUNC_READ,  8'h00,   8'd79,  8'd23,  1, 0,  24, 1920, 16'h077A),
      op_row(FUNC_PUT,   CHAR_LF, 8'd0,   8'd0,   1, 0,  24, 1920, 0),
      op_row(FUNC_READ,  8'h00,   8'd79,  8'd22,  1, 0,  24, 1920, 16'h077A),
      op_row(FUNC_READ,  8'h00,   8'd0,   8'd0,   0, 0,  0,  0,    0),
      op_row(FUNC_CLEAR, 8'hFF,   8'd255, 8'd255, 1, 0,  0,  0,    0),
      op_row(FUNC_READ,  8'h00,   8'd79,  8'd22,  0, 0,  0,  0,    0),
      op_row(FUNC_GOTO,  8'h00,   8'd170, 8'd85,  0, 0,  0,  0,    0)
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_item(in_item_t'({dir_tab[i].r, dir_tab[i].c, dir_tab[i].ch, dir_tab[i].f}),
                dir_tab[i].known, dir_tab[i].res);
    end

    run_phase(8'hFF, 8'd8,   8'd4,   50, 1'b1);
    run_phase(8'h00, 8'd1,   8'd1,   25, 1'b0);
    run_phase(8'h5A, 8'd0,   8'd0,   20, 1'b0);
    run_phase(8'hA5, 8'd3,   8'd2,   40, 1'b0);
    run_phase(8'h3C, 8'hFF,  8'hFF,  15, 1'b0);
    for (int k = 0; k < 3; k++) begin
      run_phase(8'($urandom), 8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)), 40, 1'b0);
    end
    run_phase(RESET_COLOR, 8'd80, 8'd25, 10, 1'b0);

    wait_idle();
    repeat (30) @(posedge clk);
    $display("Ran %0d items under %0d screen settings; %0d results checked.",
             items_sent, size_settings, results_seen);
    $display("The model saw %0d full screen sweeps from scrolls and clears.", sweep_count);
    if (err_count == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
